/* hw/rtl/frustum_cull_tester_top_macros.svh */
// Assertion macros shared by the frustum cull tester modules
`ifndef FRUSTUM_CULL_TESTER_TOP_MACROS_SVH
`define FRUSTUM_CULL_TESTER_TOP_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define FCT_ASSERT_IMP(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define FCT_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/fct_pkg.sv */
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, operation codes and constants of the frustum cull tester.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_EXTRACT = 3'd1,
    OP_BOX     = 3'd2,
    OP_SPHERE  = 3'd3,
    OP_POINT   = 3'd4,
    OP_DIST    = 3'd5,
    OP_NORMAL  = 3'd6,
    OP_NOP     = 3'd7
  } op_e;

  // Classified command handed from front to back
  typedef struct packed {
    op_e         op;
    logic        idx_ok;
    logic [2:0]  plane;
    logic [3:0]  mat_addr;
    logic [31:0] value;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bz;
  } cmd_t;

  // Saturate a 66-bit signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* hw/rtl/fct_front.sv */
// ----------------------------------------------------------------------------
// fct_front
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module fct_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [2:0]    op_i,
  input  logic [1:0]    mat_col_i,
  input  logic [1:0]    mat_row_i,
  input  logic [31:0]   value_i,
  input  logic [31:0]   vec_a_x_i,
  input  logic [31:0]   vec_a_y_i,
  input  logic [31:0]   vec_a_z_i,
  input  logic [31:0]   vec_b_x_i,
  input  logic [31:0]   vec_b_y_i,
  input  logic [31:0]   vec_b_z_i,
  input  logic [2:0]    plane_index_i,
  output logic          cmd_valid_o,
  output fct_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import fct_pkg::*;

  `include "frustum_cull_tester_top_macros.svh"

  cmd_t        mem_q [QueueDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;
  cmd_t        cin;

  // Classify the incoming beat
  always_comb begin
    cin          = '0;
    cin.op       = op_e'(op_i);
    cin.idx_ok   = (plane_index_i < 3'd6) &&
                   (op_i == OP_DIST || op_i == OP_NORMAL);
    cin.plane    = plane_index_i;
    cin.mat_addr = {mat_col_i, mat_row_i};
    cin.value    = value_i;
    cin.ax = vec_a_x_i; cin.ay = vec_a_y_i; cin.az = vec_a_z_i;
    cin.bx = vec_b_x_i; cin.by = vec_b_y_i; cin.bz = vec_b_z_i;
  end

  assign busy_o = (cnt_q == 2'(QueueDepth));
  assign push   = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o  = mem_q[rp_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cin;
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  `FCT_ASSERT_IMP(a_pop_ne, clk_i, rst_ni, cmd_pop_i, cnt_q != 2'd0)
  `FCT_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= 2'(QueueDepth))
  `FCT_ASSERT_NEXT(a_push_cnt, clk_i, rst_ni, push && !cmd_pop_i, cnt_q != 2'd0)
endmodule

/* hw/rtl/fct_back.sv */
// ----------------------------------------------------------------------------
// fct_back
// Executes queued commands: matrix writes, plane extraction, plane tests and distance/normal reads.
// ----------------------------------------------------------------------------
module fct_back #(
  parameter int unsigned FracBits = fct_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  fct_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          done_o,
  output logic          visible_o,
  output logic [31:0]   distance_o,
  output logic [31:0]   normal_x_o,
  output logic [31:0]   normal_y_o,
  output logic [31:0]   normal_z_o,
  output logic          index_ok_o
);
  import fct_pkg::*;

  `include "frustum_cull_tester_top_macros.svh"

  localparam int unsigned NormMin = ((1 << FracBits) + 5000) / 10000;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_DONE = 4'd3;
  localparam logic [3:0] S_XRAW = 4'd4;
  localparam logic [3:0] S_XSQ  = 4'd5;
  localparam logic [3:0] S_XSQR = 4'd6;
  localparam logic [3:0] S_XDIV = 4'd7;
  localparam logic [3:0] S_XWR  = 4'd8;

  logic [3:0]  st_q, st_d;
  cmd_t        cmd_q;
  logic [31:0] mat_q [16];
  logic [31:0] pl_q  [24];
  logic [2:0]  p_q;
  logic [1:0]  c_q;
  logic        vis_q;
  logic signed [65:0] acc_q;
  logic signed [65:0] sq_q;
  logic [31:0] raw_q [4];
  logic [63:0] rem_q, res_q, bit_q;
  logic [31:0] len_q;
  logic [5:0]  it_q;
  logic [64:0] num_q;
  logic [32:0] quo_q;
  logic        done_q;
  logic [31:0] dist_q, nx_q, ny_q, nz_q;
  logic        ok_q;

  // Current plane operand selection
  logic [4:0]  pb;
  logic signed [31:0] coef, xin, xsel;
  logic signed [65:0] prod, psh, thr;
  logic [1:0]  row;
  logic signed [32:0] rsum;
  logic [31:0] rabs;
  logic [63:0] tr;
  logic [4:0]  sh;
  logic        fail;
  logic [31:0] pl_wr;

  assign pb   = {p_q, 2'b00};
  assign coef = $signed(pl_q[5'(pb + 5'(c_q))]);
  always_comb begin
    unique case (c_q)
      2'd0: begin xin = $signed(cmd_q.ax); xsel = $signed(cmd_q.bx); end
      2'd1: begin xin = $signed(cmd_q.ay); xsel = $signed(cmd_q.by); end
      default: begin xin = $signed(cmd_q.az); xsel = $signed(cmd_q.bz); end
    endcase
    if (cmd_q.op == OP_BOX && !coef[31]) xin = xsel;
  end
  assign prod = 66'(coef) * 66'(xin);
  // exact sum scaled back in Q step: floor of sum/2^F plus d
  assign psh  = acc_q >>> FracBits;
  assign thr  = (cmd_q.op == OP_SPHERE) ? -(66'($signed(cmd_q.value)) <<< FracBits) : '0;
  // plane rejects the object: exact dot product below the threshold
  assign fail = (acc_q + (66'($signed(pl_q[5'(pb + 5'd3)])) <<< FracBits)) < thr;

  assign row  = p_q[2:1];
  assign rsum = p_q[0] ? 33'($signed(mat_q[{c_q, 2'd3}])) - 33'($signed(mat_q[{c_q, row}]))
                       : 33'($signed(mat_q[{c_q, 2'd3}])) + 33'($signed(mat_q[{c_q, row}]));
  assign rabs = raw_q[c_q][31] ? 32'(-raw_q[c_q]) : raw_q[c_q];
  assign tr   = res_q + bit_q;
  assign sh   = 5'(FracBits);

  // Normalized component, or the raw one when the length is too small
  assign pl_wr = (len_q > 32'(NormMin)) ?
                 (raw_q[c_q][31] ? sat32(-66'(quo_q)) : sat32(66'(quo_q))) : raw_q[c_q];

  // Sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (cmd_valid_i) begin
        if (cmd_i.op == OP_EXTRACT) st_d = S_XRAW;
        else if (cmd_i.op == OP_BOX || cmd_i.op == OP_SPHERE || cmd_i.op == OP_POINT ||
                 (cmd_i.op == OP_DIST && cmd_i.idx_ok)) st_d = S_MUL;
        else st_d = S_DONE;
      end
      S_MUL:  if (c_q == 2'd2) st_d = S_SUM;
      S_SUM:  st_d = (cmd_q.op == OP_DIST || p_q == 3'd5 || fail) ? S_DONE : S_MUL;
      S_DONE: st_d = S_IDLE;
      S_XRAW: if (c_q == 2'd3) st_d = S_XSQ;
      S_XSQ:  if (c_q == 2'd2) st_d = S_XSQR;
      S_XSQR: if (it_q == 6'd31) st_d = S_XDIV;
      S_XDIV: if (it_q == 6'd1) st_d = S_XWR;
      S_XWR:  st_d = (c_q == 2'd3 && p_q == 3'd5) ? S_DONE :
                     (c_q == 2'd3 ? S_XRAW : S_XDIV);
      default: st_d = S_IDLE;
    endcase
  end

  assign cmd_pop_o = (st_q == S_IDLE) && cmd_valid_i;

  // Matrix and plane registers, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
      for (int i = 0; i < 24; i++) pl_q[i] <= '0;
    end else begin
      if (st_q == S_IDLE && cmd_valid_i && cmd_i.op == OP_WRITE)
        mat_q[cmd_i.mat_addr] <= cmd_i.value;
      if (st_q == S_XWR) pl_q[5'(pb + 5'(c_q))] <= pl_wr;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        cmd_q <= cmd_i; c_q <= 2'd0; vis_q <= 1'b1;
        p_q <= (cmd_i.op == OP_DIST) ? cmd_i.plane : 3'd0;
        acc_q <= '0;
      end
      S_MUL: begin
        acc_q <= acc_q + prod;
        c_q   <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
      end
      S_SUM: begin
        if (fail) vis_q <= 1'b0;
        dist_q <= sat32(psh + 66'($signed(pl_q[5'(pb + 5'd3)])));
        acc_q <= '0;
        p_q <= p_q + 3'd1;
      end
      S_XRAW: begin
        raw_q[c_q] <= sat32(66'(rsum));
        c_q <= c_q + 2'd1;
        sq_q <= '0;
      end
      S_XSQ: begin
        sq_q <= sq_q + 66'({32'd0, rabs} * {32'd0, rabs});
        c_q  <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
        rem_q <= 64'(sq_q + 66'({32'd0, rabs} * {32'd0, rabs}));
        res_q <= '0; bit_q <= 64'h4000_0000_0000_0000; it_q <= 6'd0;
      end
      S_XSQR: begin
        // one result bit per step
        if (rem_q >= tr) begin
          rem_q <= rem_q - tr; res_q <= (res_q >> 1) + bit_q;
        end else res_q <= res_q >> 1;
        bit_q <= bit_q >> 2;
        it_q  <= (it_q == 6'd31) ? 6'd0 : it_q + 6'd1;
        if (it_q == 6'd31) begin
          len_q <= (rem_q >= tr) ? 32'((res_q >> 1) + bit_q) : 32'(res_q >> 1);
          c_q   <= 2'd0;
        end
      end
      S_XDIV: begin
        if (it_q == 6'd0) begin
          num_q <= (65'(rabs) << sh) + 65'(len_q >> 1);
          quo_q <= '0;
          it_q  <= 6'd33;
        end
      end
      S_XWR: begin
        c_q <= c_q + 2'd1;
        if (c_q == 2'd3) p_q <= p_q + 3'd1;
      end
      default: ;
    endcase
    // restoring divide, one quotient bit per cycle
    if (st_q == S_XDIV && it_q != 6'd0) begin
      it_q <= it_q - 6'd1;
      if ((num_q >> (it_q - 6'd1)) >= 65'(len_q)) begin
        num_q <= num_q - (65'(len_q) << (it_q - 6'd1));
        quo_q <= {quo_q[31:0], 1'b1};
      end else quo_q <= {quo_q[31:0], 1'b0};
    end
    if (st_q == S_DONE) begin
      nx_q <= pl_q[{cmd_q.plane[2:0], 2'd0}];
      ny_q <= pl_q[5'({cmd_q.plane[2:0], 2'd0} + 5'd1)];
      nz_q <= pl_q[5'({cmd_q.plane[2:0], 2'd0} + 5'd2)];
      ok_q <= cmd_q.idx_ok;
    end
  end

  // State and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      done_q <= (st_q == S_DONE);
    end
  end

  // Result fields, zero where the op gives them no meaning
  assign done_o     = done_q;
  assign index_ok_o = ok_q;
  assign visible_o  = (cmd_q.op == OP_BOX || cmd_q.op == OP_SPHERE ||
                       cmd_q.op == OP_POINT) && vis_q;
  assign distance_o = (cmd_q.op == OP_DIST && ok_q) ? dist_q : '0;
  assign normal_x_o = (cmd_q.op == OP_NORMAL && ok_q) ? nx_q : '0;
  assign normal_y_o = (cmd_q.op == OP_NORMAL && ok_q) ? ny_q : '0;
  assign normal_z_o = (cmd_q.op == OP_NORMAL && ok_q) ? nz_q : '0;

  `FCT_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q)
  `FCT_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, cmd_pop_o, st_q == S_IDLE)
  `FCT_ASSERT_NEXT(a_done_from, clk_i, rst_ni, st_q == S_DONE, done_q)
endmodule

/* hw/rtl/frustum_cull_tester_top.sv */
// Box, sphere and point tests run the planes in turn on a shared multiply-add and stop at the
// first reject. The back end takes the next queued command only once the last one is done.
// Plane extraction forms each plane's raw row sums, the squared length of its normal, a
// bit-serial square root and a bit-serial divide per component. A two-entry queue takes
// beats; results cannot stall. Asynchronous active-low reset clears matrix and planes to zero.
// ----------------------------------------------------------------------------
// frustum_cull_tester_top
// View-frustum culling tester: queued front end and sequenced back end.
// ----------------------------------------------------------------------------
module frustum_cull_tester_top #(
  parameter int unsigned FracBits = fct_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [1:0]  mat_col_i,
  input  logic [1:0]  mat_row_i,
  input  logic [31:0] value_i,
  input  logic [31:0] vec_a_x_i,
  input  logic [31:0] vec_a_y_i,
  input  logic [31:0] vec_a_z_i,
  input  logic [31:0] vec_b_x_i,
  input  logic [31:0] vec_b_y_i,
  input  logic [31:0] vec_b_z_i,
  input  logic [2:0]  plane_index_i,
  output logic        done_o,
  output logic        visible_o,
  output logic [31:0] distance_o,
  output logic [31:0] normal_x_o,
  output logic [31:0] normal_y_o,
  output logic [31:0] normal_z_o,
  output logic        index_ok_o
);
  import fct_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // Front end
  fct_front u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .op_i, .mat_col_i, .mat_row_i,
    .value_i, .vec_a_x_i, .vec_a_y_i, .vec_a_z_i, .vec_b_x_i, .vec_b_y_i, .vec_b_z_i,
    .plane_index_i, .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  // Back end
  fct_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .done_o, .visible_o, .distance_o, .normal_x_o, .normal_y_o, .normal_z_o, .index_ok_o
  );
endmodule
